// ===== design/efe_pkg.sv =====
// Shared constants, payload types and helper functions for the Elias-Fano stream encoder.
// No dependencies; compile first.
`default_nettype none

package efe_pkg;

  localparam int unsigned VALUE_BITS_DEF     = 64;
  localparam int unsigned MAX_LOWER_BITS_DEF = 56;
  localparam int unsigned COUNT_BITS_DEF     = 32;

  localparam int unsigned WORD_W        = 64;
  localparam int unsigned ZW_W          = 27;
  localparam int unsigned BYTES_W       = 4;
  localparam int unsigned LW_W          = 6;
  localparam int unsigned IDX_W         = 28;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned MAX_RES       = 4;
  localparam int unsigned PUSH_N_W      = $clog2(MAX_RES + 1);
  localparam int unsigned OQ_DEPTH      = 8;
  localparam int unsigned OQ_AW         = $clog2(OQ_DEPTH);
  localparam int unsigned DERIVE_CYCLES = 3;
  localparam int unsigned BUSY_W        = $clog2(DERIVE_CYCLES + 1);

  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

  localparam logic STREAM_LOWER = 1'b0;
  localparam logic STREAM_UPPER = 1'b1;

  localparam logic [ZW_W-1:0]    ZW_MAX     = '1;
  localparam logic [BYTES_W-1:0] BYTES_FULL = 4'd8;

  typedef struct packed {
    logic [WORD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic               stream;
    logic [WORD_W-1:0]  word;
    logic [ZW_W-1:0]    zero_words;
    logic [BYTES_W-1:0] bytes_in_last;
    logic               error;
    logic               end_res;
  } res_t;

  typedef struct packed {
    logic [PUSH_N_W-1:0]     n;
    res_t [MAX_RES-1:0]      item;
  } push_t;

  function automatic logic [LW_W-1:0] flog2(input logic [WORD_W-1:0] x);
    logic [LW_W-1:0] r;
    r = '0;
    for (int i = 1; i < WORD_W; i++) begin
      if (x[i]) r = LW_W'(i);
    end
    return r;
  endfunction

  function automatic logic [ZW_W-1:0] sat_zw(input logic [WORD_W-1:0] z);
    return (z > WORD_W'(ZW_MAX)) ? ZW_MAX : z[ZW_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/efe_stream_if.sv =====
// Valid/ready channel carrying one payload of type T per transaction.
// No dependencies.
`default_nettype none

interface efe_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/elias_fano_stream_encoder_top.sv =====
// Elias-Fano stream encoder: accepts sorted values and issues lower and upper words. Each item
// enters an input register and is encoded from there; its zero to four results go into an
// 8-entry result queue, which hands out one result per cycle while the output is ready. An item
// is taken every cycle while the queue holds at most four results and no configuration change
// is being derived, so the sustained rate is one item per cycle when items average at most one
// result each, and otherwise is set by the one-result-per-cycle output port. After any
// configuration write, input is held while the lower width and bitmap length are derived from
// the registers. Depends on efe_pkg, efe_stream_if, efe_cfg, efe_core, efe_outq.
`default_nettype none

module elias_fano_stream_encoder_top #(
  parameter int unsigned VALUE_BITS     = efe_pkg::VALUE_BITS_DEF,
  parameter int unsigned MAX_LOWER_BITS = efe_pkg::MAX_LOWER_BITS_DEF,
  parameter int unsigned COUNT_BITS     = efe_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [efe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [efe_pkg::WORD_W-1:0]    cfg_wdata_i,
  efe_stream_if.sink                         in_i,
  efe_stream_if.source                       out_o
);
  import efe_pkg::*;

  logic [VALUE_BITS-1:0] cfg_base, cfg_top;
  logic [COUNT_BITS-1:0] cfg_count;
  logic [LW_W-1:0]       cfg_lw;
  logic [WORD_W-1:0]     cfg_ub_m1;
  logic                  cfg_ready, room;
  push_t                 push;

  efe_cfg #(
    .VALUE_BITS    (VALUE_BITS),
    .MAX_LOWER_BITS(MAX_LOWER_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .base_o     (cfg_base),
    .top_o      (cfg_top),
    .count_o    (cfg_count),
    .lw_o       (cfg_lw),
    .ub_m1_o    (cfg_ub_m1),
    .ready_o    (cfg_ready)
  );

  efe_core #(
    .VALUE_BITS    (VALUE_BITS),
    .MAX_LOWER_BITS(MAX_LOWER_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .base_i     (cfg_base),
    .top_i      (cfg_top),
    .count_i    (cfg_count),
    .lw_i       (cfg_lw),
    .ub_m1_i    (cfg_ub_m1),
    .cfg_ready_i(cfg_ready),
    .room_i     (room),
    .push_o     (push)
  );

  efe_outq u_outq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .room_o(room),
    .out_o (out_o)
  );

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n != '0) |-> room)
    else $error("results pushed into a full result queue");

  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.n != '0) |=> out_o.valid)
    else $error("pushed results not presented on the output");

  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> ##2 !(in_i.valid && in_i.ready))
    else $error("transaction taken before derived settings settled");

endmodule

`default_nettype wire

// ===== design/efe_cfg.sv =====
// Configuration registers and derived encoding geometry (lower width, bitmap length).
// Depends on efe_pkg.
`default_nettype none

module efe_cfg #(
  parameter int unsigned VALUE_BITS     = efe_pkg::VALUE_BITS_DEF,
  parameter int unsigned MAX_LOWER_BITS = efe_pkg::MAX_LOWER_BITS_DEF,
  parameter int unsigned COUNT_BITS     = efe_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [efe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [efe_pkg::WORD_W-1:0]     cfg_wdata_i,
  output logic      [VALUE_BITS-1:0]          base_o,
  output logic      [VALUE_BITS-1:0]          top_o,
  output logic      [COUNT_BITS-1:0]          count_o,
  output logic      [efe_pkg::LW_W-1:0]       lw_o,
  output logic      [efe_pkg::WORD_W-1:0]     ub_m1_o,
  output logic                                ready_o
);
  import efe_pkg::*;

  logic [VALUE_BITS-1:0] base_q, top_q, range_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [LW_W-1:0]       flr_q, flc_q, lw_q, lw_d, cand;
  logic [WORD_W-1:0]     ub_m1_q, shr;
  logic [BUSY_W-1:0]     busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      top_q   <= '0;
      count_q <= '0;
      busy_q  <= BUSY_W'(DERIVE_CYCLES);
    end else begin
      if (cfg_we_i) begin
        busy_q <= BUSY_W'(DERIVE_CYCLES);
        case (cfg_idx_i)
          REG_BASE:  base_q  <= cfg_wdata_i[VALUE_BITS-1:0];
          REG_TOP:   top_q   <= cfg_wdata_i[VALUE_BITS-1:0];
          REG_COUNT: count_q <= cfg_wdata_i[COUNT_BITS-1:0];
          default:   ;
        endcase
      end else if (busy_q != '0) begin
        busy_q <= busy_q - BUSY_W'(1);
      end
    end
  end

  // L = floor(log2(range / count)), capped at MAX_LOWER_BITS, found from the leading-one positions
  always_comb begin
    cand = flr_q - flc_q;
    shr  = WORD_W'(range_q) >> cand;
    if (count_q == '0 || WORD_W'(range_q) < WORD_W'(count_q)) begin
      lw_d = '0;
    end else begin
      lw_d = (WORD_W'(count_q) > shr) ? cand - LW_W'(1) : cand;
      if (lw_d > LW_W'(MAX_LOWER_BITS)) lw_d = LW_W'(MAX_LOWER_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    range_q <= top_q - base_q;
    flr_q   <= flog2(WORD_W'(top_q - base_q));
    flc_q   <= flog2(WORD_W'(count_q));
    lw_q    <= lw_d;
    ub_m1_q <= (WORD_W'(range_q) >> lw_q) + WORD_W'(count_q) - WORD_W'(1);
  end

  assign base_o  = base_q;
  assign top_o   = top_q;
  assign count_o = count_q;
  assign lw_o    = lw_q;
  assign ub_m1_o = ub_m1_q;
  assign ready_o = (busy_q == '0);

endmodule

`default_nettype wire

// ===== design/efe_core.sv =====
// Input register, per-element encode logic and sequence state; emits up to four results.
// Depends on efe_pkg and efe_stream_if.
`default_nettype none

module efe_core #(
  parameter int unsigned VALUE_BITS     = efe_pkg::VALUE_BITS_DEF,
  parameter int unsigned MAX_LOWER_BITS = efe_pkg::MAX_LOWER_BITS_DEF,
  parameter int unsigned COUNT_BITS     = efe_pkg::COUNT_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  efe_stream_if.sink                       in_i,
  input  wire logic [VALUE_BITS-1:0]       base_i,
  input  wire logic [VALUE_BITS-1:0]       top_i,
  input  wire logic [COUNT_BITS-1:0]       count_i,
  input  wire logic [efe_pkg::LW_W-1:0]    lw_i,
  input  wire logic [efe_pkg::WORD_W-1:0]  ub_m1_i,
  input  wire logic                        cfg_ready_i,
  input  wire logic                        room_i,
  output efe_pkg::push_t                   push_o
);
  import efe_pkg::*;

  localparam int unsigned LOWW = (VALUE_BITS < MAX_LOWER_BITS) ? VALUE_BITS : MAX_LOWER_BITS;

  function automatic res_t mk_res(input logic s, input logic [WORD_W-1:0] w,
                                  input logic [ZW_W-1:0] zw, input logic [BYTES_W-1:0] b);
    res_t r;
    r               = '0;
    r.stream        = s;
    r.word          = w;
    r.zero_words    = zw;
    r.bytes_in_last = b;
    return r;
  endfunction

  // input register
  logic                  in_valid_q, rng_err_q;
  logic [VALUE_BITS-1:0] val_q, hi_q;
  logic [LOWW-1:0]       low_q;

  // sequence state
  logic [WORD_W-1:0]     pend_q, cur_q;
  logic [LW_W-1:0]       fill_q;
  logic [IDX_W-1:0]      idx_q;
  logic [COUNT_BITS-1:0] done_q;
  logic [VALUE_BITS-1:0] prev_q;

  logic                  accept, consume;
  logic [VALUE_BITS-1:0] diff, lmask;

  logic                  err, full, adv, last_el;
  logic [LW_W:0]         sum;
  logic [2*WORD_W-1:0]   wide;
  logic [WORD_W-1:0]     pend_or, pend_n, cur_n, bitv, pos, wi, lastw, zw_fin;
  logic [LW_W-1:0]       fill_n;
  logic [IDX_W-1:0]      idx_n;
  logic [COUNT_BITS-1:0] done_n;
  logic [PUSH_N_W-1:0]   n;

  assign diff    = in_i.data.value[VALUE_BITS-1:0] - base_i;
  assign lmask   = (VALUE_BITS'(1) << lw_i) - VALUE_BITS'(1);
  assign in_i.ready = cfg_ready_i && (!in_valid_q || room_i);
  assign accept  = in_i.valid && in_i.ready;
  assign consume = in_valid_q && room_i;

  always_comb begin
    err = (done_q >= count_i) || rng_err_q || ((done_q != '0) && (val_q < prev_q));

    sum     = (LW_W + 1)'(fill_q) + (LW_W + 1)'(lw_i);
    full    = sum[LW_W];
    fill_n  = sum[LW_W-1:0];
    wide    = (2 * WORD_W)'(low_q) << fill_q;
    pend_or = pend_q | wide[WORD_W-1:0];
    pend_n  = full ? wide[2*WORD_W-1:WORD_W] : pend_or;

    pos   = WORD_W'(hi_q) + WORD_W'(done_q);
    wi    = pos >> 6;
    adv   = wi > WORD_W'(idx_q);
    bitv  = WORD_W'(1) << pos[5:0];
    cur_n = adv ? bitv : (cur_q | bitv);
    idx_n = adv ? wi[IDX_W-1:0] : idx_q;

    done_n  = done_q + COUNT_BITS'(1);
    last_el = (done_n == count_i);

    lastw  = ub_m1_i >> 6;
    zw_fin = (lastw > WORD_W'(idx_n)) ? lastw - WORD_W'(idx_n) : '0;

    push_o = '0;
    n      = '0;
    if (consume) begin
      if (err) begin
        push_o.item[0].error = 1'b1;
        n = PUSH_N_W'(1);
      end else begin
        if (full) begin
          push_o.item[n[1:0]] = mk_res(STREAM_LOWER, pend_or, '0, BYTES_FULL);
          n = n + PUSH_N_W'(1);
        end
        if (adv) begin
          push_o.item[n[1:0]] = mk_res(STREAM_UPPER, cur_q,
                                       sat_zw(wi - WORD_W'(idx_q) - WORD_W'(1)), BYTES_FULL);
          n = n + PUSH_N_W'(1);
        end
        if (last_el) begin
          if (fill_n != '0) begin
            push_o.item[n[1:0]] = mk_res(STREAM_LOWER, pend_n, '0,
                                         BYTES_W'(((LW_W + 1)'(fill_n) + (LW_W + 1)'(7)) >> 3));
            n = n + PUSH_N_W'(1);
          end
          push_o.item[n[1:0]] = mk_res(STREAM_UPPER, cur_n, sat_zw(zw_fin),
                                       BYTES_W'(ub_m1_i[5:3]) + BYTES_W'(1));
          n = n + PUSH_N_W'(1);
        end
      end
    end
    if (n != '0) push_o.item[2'(n - PUSH_N_W'(1))].end_res = 1'b1;
    push_o.n = n;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q     <= in_i.data.value[VALUE_BITS-1:0];
      hi_q      <= diff >> lw_i;
      low_q     <= LOWW'(diff & lmask);
      rng_err_q <= (in_i.data.value[VALUE_BITS-1:0] < base_i) ||
                   (in_i.data.value[VALUE_BITS-1:0] > top_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pend_q     <= '0;
      fill_q     <= '0;
      cur_q      <= '0;
      idx_q      <= '0;
      done_q     <= '0;
      prev_q     <= '0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      if (consume && !err) begin
        if (last_el) begin
          pend_q <= '0;
          fill_q <= '0;
          cur_q  <= '0;
          idx_q  <= '0;
          done_q <= '0;
          prev_q <= '0;
        end else begin
          pend_q <= pend_n;
          fill_q <= fill_n;
          cur_q  <= cur_n;
          idx_q  <= idx_n;
          done_q <= done_n;
          prev_q <= val_q;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/efe_outq.sv =====
// Result queue: takes up to four results per cycle, hands out one per transaction.
// Depends on efe_pkg and efe_stream_if.
`default_nettype none

module efe_outq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire efe_pkg::push_t push_i,
  output logic                room_o,
  efe_stream_if.source        out_o
);
  import efe_pkg::*;

  res_t             mem [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OQ_AW:0]   level_q;
  logic             pop;

  assign out_o.valid = (level_q != '0);
  assign out_o.data  = mem[rd_ptr_q];
  assign pop         = out_o.valid && out_o.ready;
  assign room_o      = (level_q <= (OQ_AW + 1)'(OQ_DEPTH - MAX_RES));

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < OQ_DEPTH; i++) begin
      for (int k = 0; k < MAX_RES; k++) begin
        if (PUSH_N_W'(k) < push_i.n && OQ_AW'(wr_ptr_q + OQ_AW'(k)) == OQ_AW'(i)) begin
          mem[i] <= push_i.item[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + OQ_AW'(push_i.n);
      if (pop) rd_ptr_q <= rd_ptr_q + OQ_AW'(1);
      level_q  <= level_q + (OQ_AW + 1)'(push_i.n) - (OQ_AW + 1)'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for elias_fano_stream_encoder_top: directed cases, then random mostly sorted sequences.
// A scoreboard class predicts the lower and upper stream words and checks each one in order.
// Depends on efe_pkg, efe_stream_if and the encoder RTL.

module testbench;
  import efe_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [WORD_W-1:0] ALL_ONES = '1;
  localparam int unsigned VALUE_TARGET = 370;
  localparam int unsigned SETTLE_CYCLES = 12;

  class ef_scoreboard;
    bit [63:0] base_reg;
    bit [63:0] top_reg;
    bit [31:0] count_reg;
    bit [63:0] lower_word;
    int unsigned lower_fill;
    bit [63:0] upper_word;
    bit [63:0] upper_idx;
    bit [31:0] done;
    bit [63:0] prev;
    res_t words_due[$];
    res_t burst[$];
    int unsigned mismatches;

    task report(string msg);
      if (mismatches < 100) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [63:0] data);
      case (idx)
        REG_BASE:  base_reg = data;
        REG_TOP:   top_reg = data;
        REG_COUNT: count_reg = data[31:0];
        default: ;
      endcase
    endfunction

    function void clear_seq();
      lower_word = '0;
      lower_fill = 0;
      upper_word = '0;
      upper_idx = '0;
      done = '0;
      prev = '0;
    endfunction

    function int unsigned msb(bit [63:0] x);
      for (int i = 63; i > 0; i--) begin
        if (x[i]) return i;
      end
      return 0;
    endfunction

    function int unsigned lower_bits_for(bit [63:0] rng, bit [63:0] cnt);
      int unsigned c;
      int unsigned w;
      if (cnt == 0 || rng < cnt) return 0;
      c = msb(rng) - msb(cnt);
      w = (cnt > (rng >> c)) ? c - 1 : c;
      return (w > MAX_LOWER_BITS_DEF) ? MAX_LOWER_BITS_DEF : w;
    endfunction

    function void emit(logic s, bit [63:0] w, bit [63:0] zw, bit [63:0] nb);
      res_t r;
      r = '0;
      r.stream = s;
      r.word = w;
      r.zero_words = (zw > 64'(ZW_MAX)) ? ZW_MAX : zw[ZW_W-1:0];
      r.bytes_in_last = nb[BYTES_W-1:0];
      burst.insert(burst.size(), r);
    endfunction

    function void encode_value(bit [63:0] val);
      bit [63:0] rng;
      bit [63:0] v;
      bit [63:0] low;
      bit [63:0] pos;
      bit [63:0] wi;
      bit [63:0] ub;
      bit [63:0] last_idx;
      bit [63:0] zw;
      int unsigned l;
      res_t r;
      if (done >= count_reg || val < base_reg || val > top_reg || (done != 0 && val < prev)) begin
        r = '0;
        r.error = 1'b1;
        r.end_res = 1'b1;
        words_due.insert(words_due.size(), r);
        return;
      end
      rng = top_reg - base_reg;
      l = lower_bits_for(rng, {32'd0, count_reg});
      v = val - base_reg;
      if (l != 0) begin
        low = v & ((64'd1 << l) - 64'd1);
        lower_word |= low << lower_fill;
        if (lower_fill + l >= 64) begin
          emit(STREAM_LOWER, lower_word, 0, 64'(BYTES_FULL));
          lower_word = low >> (64 - lower_fill);
          lower_fill = lower_fill + l - 64;
        end else begin
          lower_fill = lower_fill + l;
        end
      end
      pos = (v >> l) + {32'd0, done};
      wi = pos >> 6;
      if (wi > upper_idx) begin
        emit(STREAM_UPPER, upper_word, wi - upper_idx - 1, 64'(BYTES_FULL));
        upper_idx = {36'd0, wi[IDX_W-1:0]};
        upper_word = 64'd1 << pos[5:0];
      end else begin
        upper_word |= 64'd1 << pos[5:0];
      end
      prev = val;
      done++;
      if (done == count_reg) begin
        ub = (rng >> l) + {32'd0, count_reg};
        last_idx = (ub - 1) >> 6;
        zw = (last_idx > upper_idx) ? last_idx - upper_idx : 64'd0;
        if (lower_fill != 0) emit(STREAM_LOWER, lower_word, 0, (lower_fill + 7) >> 3);
        emit(STREAM_UPPER, upper_word, zw, (((ub - 1) & 64'd63) >> 3) + 1);
        clear_seq();
      end
      if (burst.size() != 0) burst[burst.size() - 1].end_res = 1'b1;
      foreach (burst[k]) words_due.insert(words_due.size(), burst[k]);
      burst.delete();
    endfunction

    task compare_field(string name, bit [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_word(res_t got);
      res_t want;
      if (words_due.size() == 0) begin
        report($sformatf("transaction with nothing pending: %h", got));
        return;
      end
      want = words_due.pop_front();
      compare_field("stream", got.stream, want.stream);
      compare_field("word", got.word, want.word);
      compare_field("zero_words", got.zero_words, want.zero_words);
      compare_field("bytes_in_last", got.bytes_in_last, want.bytes_in_last);
      compare_field("error", got.error, want.error);
      compare_field("end_res", got.end_res, want.end_res);
    endtask

    task close_out();
      if (words_due.size() != 0) report($sformatf("%0d words never came out", words_due.size()));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [WORD_W-1:0] cfg_wdata;
  ef_scoreboard sb;
  int unsigned values_sent;
  bit steady_source;
  bit steady_sink;

  efe_stream_if #(.T(in_t)) in_if ();
  efe_stream_if #(.T(res_t)) out_if ();

  elias_fano_stream_encoder_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_upto(logic [63:0] lim);
    if (lim == ALL_ONES) return rand64();
    return rand64() % (lim + 64'd1);
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    if (steady_source) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int unsigned stall_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(30, 60);
  endfunction

  // next element of a well-formed sequence under the current registers
  function automatic logic [63:0] pick_sorted();
    logic [63:0] lo;
    logic [63:0] room;
    logic [63:0] avg;
    logic [63:0] lim;
    bit [31:0] left;
    lo = (sb.done != 0 && sb.prev > sb.base_reg) ? sb.prev : sb.base_reg;
    if (lo > sb.top_reg || sb.done >= sb.count_reg) return lo;
    left = sb.count_reg - sb.done;
    room = sb.top_reg - lo;
    avg = room / {32'd0, left};
    lim = (avg > (room >> 1)) ? room : avg << 1;
    if (left == 1 && $urandom_range(0, 3) == 0) return sb.top_reg;
    case ($urandom_range(0, 19))
      0, 1: return lo;
      2: return lo + room;
      3: return lo + pick_upto(room);
      default: return lo + pick_upto(lim);
    endcase
  endfunction

  // below base, above top, out of order, or anything
  function automatic logic [63:0] pick_stray();
    case ($urandom_range(0, 3))
      0: if (sb.base_reg != 0) return pick_upto(sb.base_reg - 1);
      1: if (sb.top_reg != ALL_ONES) return sb.top_reg + 1 + pick_upto(ALL_ONES - sb.top_reg - 1);
      2: if (sb.done != 0 && sb.prev > sb.base_reg)
           return sb.base_reg + pick_upto(sb.prev - sb.base_reg - 1);
      default: ;
    endcase
    return rand64();
  endfunction

  task automatic send_value(logic [63:0] v);
    int unsigned gap;
    gap = gap_len();
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.data.value <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.encode_value(v);
    values_sent++;
    if (gap != 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [63:0] b, logic [63:0] t, logic [63:0] c);
    wait_idle();
    write_reg(REG_BASE, b);
    write_reg(REG_TOP, t);
    write_reg(REG_COUNT, c);
  endtask

  task automatic finish_open_sequence();
    while (sb.done != 0 && sb.done < sb.count_reg) send_value(pick_sorted());
  endtask

  initial begin : result_pacing
    int unsigned hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
        if (!steady_sink && $urandom_range(0, 99) < 30) hold = stall_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_word(out_if.data);
  end

  initial begin : stimulus
    logic [63:0] b;
    logic [63:0] t;
    logic [63:0] span;
    logic [63:0] cw;
    int unsigned kind;
    int unsigned c;
    int unsigned k;
    int unsigned n_items;
    sb = new();
    values_sent = 0;
    steady_source = 1'b0;
    steady_sink = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_BASE;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // count is zero after reset: excess
    send_value('0);
    send_value(ALL_ONES);
    wait_idle();
    write_reg(REG_UNUSED, rand64());
    // full range, two elements: the second one drives all four words
    set_config('0, ALL_ONES, 2);
    send_value('0);
    send_value(ALL_ONES);
    set_config('0, ALL_ONES, 1);
    send_value(ALL_ONES);
    // empty range, lower width zero, repeated values, out of range both sides
    set_config(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 3);
    send_value(64'h7FFF_FFFF_FFFF_FFFF);
    send_value(64'h8000_0000_0000_0001);
    repeat (3) send_value(64'h8000_0000_0000_0000);
    // top below base
    set_config(100, 50, 4);
    send_value(75);
    // out of order, last element at top
    set_config(1000, 1000000, 4);
    send_value(5000);
    send_value(4000);
    send_value(6000);
    send_value(6000);
    send_value(1000000);
    // largest count, then count lowered and raised in the middle of a sequence
    set_config('0, ALL_ONES, {32'hA5C3_0F96, 32'hFFFF_FFFF});
    send_value(3);
    send_value(64'hFFFF_FFFF_0000_0000);
    wait_idle();
    write_reg(REG_COUNT, 2);
    send_value(7);
    wait_idle();
    write_reg(REG_COUNT, 3);
    send_value(ALL_ONES);

    while (values_sent < VALUE_TARGET) begin
      steady_source = ($urandom_range(0, 3) == 0);
      steady_sink = ($urandom_range(0, 3) == 0);
      if (sb.done != 0 && $urandom_range(0, 1) == 0) begin
        // widen the range and retarget the count mid-sequence
        t = sb.top_reg + pick_upto((ALL_ONES - sb.top_reg) >> $urandom_range(0, 63));
        k = $urandom_range(0, 3);
        wait_idle();
        write_reg(REG_TOP, t);
        cw = rand64();
        cw[31:0] = sb.done + k;
        write_reg(REG_COUNT, cw);
        if (k == 0) begin
          send_value(pick_sorted());
          send_value(pick_stray());
          wait_idle();
          cw = rand64();
          cw[31:0] = sb.done + $urandom_range(1, 3);
          write_reg(REG_COUNT, cw);
        end
        finish_open_sequence();
      end else begin
        finish_open_sequence();
        kind = $urandom_range(0, 18);
        b = rand64() >> $urandom_range(0, 63);
        if (kind < 6) begin
          span = $urandom_range(0, 300);
          c = $urandom_range(1, 24);
        end else if (kind < 12) begin
          span = $urandom;
          c = $urandom_range(1, 40);
        end else if (kind < 15) begin
          b = $urandom_range(0, 255);
          span = ALL_ONES - b - $urandom_range(0, 255);
          c = $urandom_range(1, 8);
        end else begin
          span = rand64() >> $urandom_range(0, 8);
          c = $urandom_range(1, 30);
        end
        if (b > ALL_ONES - span) b = ALL_ONES - span;
        t = b + span;
        if (kind == 18) begin
          if ($urandom_range(0, 1) == 0) begin
            c = 0;
          end else begin
            if (b == 0) b = 1;
            t = pick_upto(b - 1);
          end
        end
        cw = rand64();
        cw[31:0] = c;
        set_config(b, t, cw);
        if (kind == 18) begin
          n_items = $urandom_range(3, 6);
        end else begin
          n_items = c * $urandom_range(1, 2);
          if (n_items > 1 && $urandom_range(0, 4) == 0) n_items = $urandom_range(1, n_items - 1);
        end
        for (int i = 0; i < n_items; i++) begin
          if ($urandom_range(0, 11) == 0) send_value(pick_stray());
          send_value(pick_sorted());
        end
      end
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    for (int i = 0; i < 5000 && sb.words_due.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/efe_pkg.sv
design/efe_stream_if.sv
design/efe_cfg.sv
design/efe_core.sv
design/efe_outq.sv
design/elias_fano_stream_encoder_top.sv
dv/testbench.sv
